FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL top level of the candidate pool.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("candidate pool assertion failed");

// Next-cycle implication, disabled during reset.
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("candidate pool assertion failed");

`endif

FILE: hdl/scpi_pkg.sv
// Package for the sorted candidate pool: field widths, operation codes,
// the entry type and the scan control struct. No dependencies.
`default_nettype none

package scpi_pkg;

  localparam int FUNC_W    = 2;
  localparam int ID_W      = 24;
  localparam int DIST_W    = 32;
  localparam int IDX_W     = 6;
  localparam int POS_W     = 7;
  localparam int DEPTH_DEF = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
    logic              fresh;
  } entry_t;

  // Value of an entry that was never written since reset or clear
  localparam entry_t RESET_ENTRY = '{id: '0, distance: '1, fresh: 1'b0};

  typedef struct packed {
    logic init;  // start a new scan
    logic step;  // one entry arrives this cycle
  } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/scpi_req_if.sv
// Request channel of the candidate pool: valid/ready plus one input item.
// Depends on scpi_pkg for field widths.
`default_nettype none

interface scpi_req_if;
  logic                        valid;
  logic                        ready;
  logic [scpi_pkg::FUNC_W-1:0] func;
  logic [scpi_pkg::ID_W-1:0]   node_id;
  logic [scpi_pkg::DIST_W-1:0] cand_distance;
  logic                        fresh;
  logic [scpi_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, func, node_id, cand_distance, fresh, read_index,
                  input ready);
  modport sink   (input valid, func, node_id, cand_distance, fresh, read_index,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/scpi_rsp_if.sv
// Response channel of the candidate pool: valid/ready plus one result item.
// Depends on scpi_pkg for field widths.
`default_nettype none

interface scpi_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scpi_pkg::POS_W-1:0]  position;
  logic [scpi_pkg::ID_W-1:0]   entry_id;
  logic [scpi_pkg::DIST_W-1:0] entry_distance;
  logic                        entry_fresh;

  modport source (output valid, position, entry_id, entry_distance, entry_fresh,
                  input ready);
  modport sink   (input valid, position, entry_id, entry_distance, entry_fresh,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/scpi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module scpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/scpi_scan.sv
// Scan unit: counts entries at or below the candidate distance and flags an
// equal id while the pool streams past. Depends on scpi_pkg.
`default_nettype none

module scpi_scan #(
  parameter int DEPTH = scpi_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire scpi_pkg::scan_ctrl_t ctrl,
  input  wire scpi_pkg::entry_t     cand,
  input  wire scpi_pkg::entry_t     ent,
  output logic [CW-1:0]             slot,
  output logic                      dup
);
  import scpi_pkg::*;

  logic le_hit;
  logic id_hit;

  assign le_hit = (ent.distance <= cand.distance);
  assign id_hit = (ent.id == cand.id);

  // accumulate over one pass of the pool
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      slot <= '0;
      dup  <= 1'b0;
    end else if (ctrl.step) begin
      slot <= slot + CW'(le_hit);
      dup  <= dup | id_hit;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sorted_candidate_pool_insert_top.sv
// Top level of the sorted candidate pool: sequencer, valid bits, pool RAM
// and result register. Depends on scpi_pkg, scpi_req_if, scpi_rsp_if,
// scpi_ram, scpi_scan and assert_macros.svh.
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  req     | in  | func, node_id, cand_distance, fresh, read_index
//  rsp     | out | position, entry_id, entry_distance, entry_fresh
//
// One request at a time; req is ready only while the sequencer is idle, and a
// finished result waits in the rsp register while the next request is taken.
// Every insert makes one scan pass over the single RAM read port; a kept insert
// then shifts the later entries down through the write port in descending
// order and writes itself at its slot.
// Reset (synchronous, rst high) and clear mark all entries unwritten at once
// through per-entry valid bits; rsp stalls hold the sequencer in its last state.
`default_nettype none
`include "assert_macros.svh"

module sorted_candidate_pool_insert_top #(
  parameter int DEPTH = scpi_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  scpi_req_if.sink  req,
  scpi_rsp_if.source rsp
);
  import scpi_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(entry_t);

  localparam logic [POS_W-1:0] POS_NOT_KEPT = POS_W'(DEPTH);
  localparam logic [POS_W-1:0] POS_DUP      = POS_W'(DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_PLACE  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state;
  logic [DEPTH-1:0] valid;
  logic             rd_valid;
  entry_t           cand;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    sh_idx;
  logic [AW-1:0]    sh_dec;
  logic [POS_W-1:0] res_pos;
  entry_t           res_ent;
  logic             out_valid;
  logic [POS_W-1:0] out_pos;
  entry_t           out_ent;

  logic             req_fire;
  logic             rsp_free;
  logic             in_range;
  logic             keep;
  logic             wr_en;
  logic [AW-1:0]    waddr;
  entry_t           wdata;
  logic [AW-1:0]    raddr;
  logic [EW-1:0]    rdata;
  entry_t           eff;
  scan_ctrl_t       scan_ctrl;
  logic [CW-1:0]    slot;
  logic             dup;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign rsp_free  = !out_valid || rsp.ready;
  assign in_range  = (32'(req.read_index) < 32'(DEPTH));
  assign keep      = (slot != CW'(DEPTH));
  assign sh_dec    = sh_idx - AW'(1);

  // an unwritten entry reads as its reset value
  assign eff = rd_valid ? entry_t'(rdata) : RESET_ENTRY;

  scpi_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  scpi_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk  (clk),
    .ctrl (scan_ctrl),
    .cand (cand),
    .ent  (eff),
    .slot (slot),
    .dup  (dup)
  );

  // RAM addressing and scan control
  always_comb begin
    raddr     = '0;
    wr_en     = 1'b0;
    waddr     = '0;
    wdata     = cand;
    scan_ctrl = '0;
    case (state)
      S_IDLE: begin
        if (req_fire && req.func == FUNC_INSERT) begin
          scan_ctrl.init = 1'b1;
        end else if (req_fire && req.func == FUNC_READ) begin
          raddr = AW'(req.read_index);
        end
      end
      S_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (cnt != CW'(DEPTH)) begin
          raddr = cnt[AW-1:0];
        end
      end
      S_DECIDE: begin
        raddr = AW'(DEPTH - 2);
      end
      S_SHIFT: begin
        // move entry sh_idx-1 (arriving now) down to sh_idx
        wr_en = 1'b1;
        waddr = sh_idx;
        wdata = eff;
        raddr = sh_idx - AW'(2);
      end
      S_PLACE: begin
        wr_en = 1'b1;
        waddr = slot[AW-1:0];
        wdata = cand;
      end
      default: begin
      end
    endcase
  end

  // valid bit of the entry being read travels with the RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            cand    <= '{id: req.node_id, distance: req.cand_distance, fresh: req.fresh};
            res_pos <= '0;
            res_ent <= '0;
            cnt     <= CW'(1);
            case (req.func)
              FUNC_CLEAR: begin
                valid <= '0;
                state <= S_DONE;
              end
              FUNC_INSERT: begin
                state <= S_SCAN;
              end
              FUNC_READ: begin
                state <= in_range ? S_RDWAIT : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_ent <= eff;
          state   <= S_DONE;
        end
        S_SCAN: begin
          if (cnt == CW'(DEPTH)) begin
            state <= S_DECIDE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DECIDE: begin
          sh_idx <= AW'(DEPTH - 1);
          if (!keep) begin
            res_pos <= POS_NOT_KEPT;
            state   <= S_DONE;
          end else if (dup) begin
            res_pos <= POS_DUP;
            state   <= S_DONE;
          end else begin
            res_pos <= POS_W'(slot);
            if (slot == CW'(DEPTH - 1)) begin
              state <= S_PLACE;
            end else begin
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          valid[sh_idx] <= 1'b1;
          sh_idx        <= sh_dec;
          if (CW'(sh_dec) == slot) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          valid[slot[AW-1:0]] <= 1'b1;
          state               <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      out_valid <= 1'b1;
      out_pos   <= res_pos;
      out_ent   <= res_ent;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.position       = out_pos;
  assign rsp.entry_id       = out_ent.id;
  assign rsp.entry_distance = out_ent.distance;
  assign rsp.entry_fresh    = out_ent.fresh;

  // checks
  `SCP_ASSERT_NOW(a_no_write_outside_update, clk, rst,
                  state != S_SHIFT && state != S_PLACE, !wr_en)
  `SCP_ASSERT_NOW(a_shift_below_slot, clk, rst, state == S_SHIFT, CW'(sh_idx) > slot)
  `SCP_ASSERT_NOW(a_place_only_kept, clk, rst, state == S_PLACE, keep && !dup)
  `SCP_ASSERT_NEXT(a_done_loads_result, clk, rst, state == S_DONE && rsp_free,
                   state == S_IDLE && out_valid)

endmodule

`default_nettype wire

FILE: tb/scpi_pool_checker.sv
// Scoreboard for the sorted candidate pool: mirrors the pool contents, predicts
// each response from accepted request beats and compares them field by field.
// Depends on scpi_pkg, scpi_req_if and scpi_rsp_if.
`timescale 1ns / 100ps

module scpi_pool_checker #(
  parameter int DEPTH = scpi_pkg::DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  scpi_req_if      req,
  scpi_rsp_if      rsp,
  output int       fail_count,
  output int       replies_owed
);
  import scpi_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] position;
    entry_t           entry;
  } pool_reply_t;

  entry_t      pool [DEPTH];
  pool_reply_t replies_q [$];

  initial begin
    fail_count   = 0;
    replies_owed = 0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  // Apply one request to the mirrored pool and return the response it should give
  function automatic pool_reply_t apply_to_pool(input logic [FUNC_W-1:0] func,
                                                input logic [ID_W-1:0]   id,
                                                input logic [DIST_W-1:0] cand_dist,
                                                input logic              fl,
                                                input logic [IDX_W-1:0]  idx);
    pool_reply_t r;
    int          slot;
    bit          dup;
    r = '0;
    case (func)
      FUNC_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) pool[i] = RESET_ENTRY;
      end
      FUNC_INSERT: begin
        // slot = number of entries at or below the candidate distance
        slot = 0;
        for (int i = 0; i < DEPTH; i++) if (pool[i].distance <= cand_dist) slot++;
        if (slot >= DEPTH) begin
          // worse than everything: not kept, checked before duplicates
          r.position = POS_W'(DEPTH);
        end else begin
          dup = 1'b0;
          for (int i = 0; i < DEPTH; i++) if (pool[i].id == id) dup = 1'b1;
          if (dup) begin
            r.position = POS_W'(DEPTH + 1);
          end else begin
            for (int i = DEPTH - 1; i > slot; i--) pool[i] = pool[i-1];
            pool[slot] = '{id: id, distance: cand_dist, fresh: fl};
            r.position = POS_W'(slot);
          end
        end
      end
      FUNC_READ: begin
        if (idx < DEPTH) r.entry = pool[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Monitor both channels; results are retired before the new request is applied
  always @(posedge clk) begin
    pool_reply_t oldest;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) pool[i] = RESET_ENTRY;
      replies_q.delete();
      replies_owed <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (replies_q.size() == 0) begin
          report_mismatch("response beat with no request outstanding");
        end else begin
          oldest = replies_q.pop_front();
          if (rsp.position !== oldest.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      rsp.position, oldest.position));
          if (rsp.entry_id !== oldest.entry.id)
            report_mismatch($sformatf("entry_id got %h want %h",
                                      rsp.entry_id, oldest.entry.id));
          if (rsp.entry_distance !== oldest.entry.distance)
            report_mismatch($sformatf("entry_distance got %h want %h",
                                      rsp.entry_distance, oldest.entry.distance));
          if (rsp.entry_fresh !== oldest.entry.fresh)
            report_mismatch($sformatf("entry_fresh got %b want %b",
                                      rsp.entry_fresh, oldest.entry.fresh));
        end
      end
      if (req.valid && req.ready)
        replies_q.insert(replies_q.size(),
                         apply_to_pool(req.func, req.node_id, req.cand_distance,
                                       req.fresh, req.read_index));
      replies_owed <= replies_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the sorted candidate pool: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on scpi_pkg, both channel
// interfaces, the pool top level and scpi_pool_checker.
`timescale 1ns / 100ps

module tb_top;
  import scpi_pkg::*;

  localparam int DEPTH           = DEPTH_DEF;
  localparam int RANDOM_ITEMS    = 2000;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_PCT        = 11;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
    logic              fresh;
    logic [IDX_W-1:0]  idx;
  } pool_req_t;

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   fail_count;
  int   replies_owed;
  bit   no_idle  = 1'b0;
  bit   hold_rsp = 1'b0;

  scpi_req_if req_ch ();
  scpi_rsp_if rsp_ch ();

  sorted_candidate_pool_insert_top #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  scpi_pool_checker #(.DEPTH(DEPTH)) pool_chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_candidate_pool_insert_top] ERROR");
      $finish;
    end
  end

  // Response side: random back-pressure, or one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic pool_req_t mk_req(input logic [FUNC_W-1:0] func,
                                       input logic [ID_W-1:0]   id,
                                       input logic [DIST_W-1:0] distance,
                                       input logic              fresh,
                                       input logic [IDX_W-1:0]  idx);
    pool_req_t r;
    r.func     = func;
    r.id       = id;
    r.distance = distance;
    r.fresh    = fresh;
    r.idx      = idx;
    return r;
  endfunction

  // Mostly inserts with a narrow id range (duplicates) and clustered distances
  function automatic pool_req_t random_req();
    pool_req_t r;
    int        pick;
    pick = $urandom_range(999);
    if (pick < 5)        r.func = FUNC_CLEAR;
    else if (pick < 35)  r.func = FUNC_UNUSED;
    else if (pick < 335) r.func = FUNC_READ;
    else                 r.func = FUNC_INSERT;
    pick = $urandom_range(99);
    if (pick < 40)      r.id = ID_W'($urandom_range(255));
    else if (pick < 90) r.id = ID_W'($urandom);
    else if (pick < 95) r.id = '0;
    else                r.id = '1;
    pick = $urandom_range(99);
    if (pick < 45)      r.distance = DIST_W'($urandom_range(4095));
    else if (pick < 75) r.distance = $urandom;
    else if (pick < 85) r.distance = '0;
    else if (pick < 92) r.distance = '1;
    else                r.distance = {1'b1, 31'($urandom)};
    r.fresh = 1'($urandom_range(1));
    r.idx   = IDX_W'($urandom);
    return r;
  endfunction

  // Present one request beat, with random idle cycles ahead of it
  task automatic offer(input pool_req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.func          <= r.func;
    req_ch.node_id       <= r.id;
    req_ch.cand_distance <= r.distance;
    req_ch.fresh         <= r.fresh;
    req_ch.read_index    <= r.idx;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stimulus and verdict
  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.func          <= FUNC_CLEAR;
    req_ch.node_id       <= '0;
    req_ch.cand_distance <= '0;
    req_ch.fresh         <= 1'b0;
    req_ch.read_index    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset contents, ordering on ties, not-kept vs duplicate, clear
    offer(mk_req(FUNC_READ,   '0, '0, 1'b0, '0));
    offer(mk_req(FUNC_READ,   '0, '0, 1'b0, '1));
    offer(mk_req(FUNC_INSERT, '0, '0, 1'b0, '0));   // id 0 matches a cleared entry
    offer(mk_req(FUNC_INSERT, '1, '1, 1'b1, '0));   // infinity vs all-infinity pool
    offer(mk_req(FUNC_INSERT, '1, '0, 1'b1, '1));
    offer(mk_req(FUNC_INSERT, 24'd1, '0, 1'b0, '0)); // tie goes after
    offer(mk_req(FUNC_INSERT, 24'd2, 32'hFFFF_FFFE, 1'b1, '0));
    offer(mk_req(FUNC_INSERT, '1, 32'd5, 1'b0, '0)); // duplicate
    offer(mk_req(FUNC_INSERT, 24'd1, '1, 1'b1, '0)); // duplicate but not kept
    offer(mk_req(FUNC_UNUSED, '1, '1, 1'b1, '1));
    for (int i = 0; i < 4; i++)
      offer(mk_req(FUNC_READ, '0, '0, 1'b0, IDX_W'(i)));
    offer(mk_req(FUNC_READ,   '1, '1, 1'b1, '1));
    offer(mk_req(FUNC_CLEAR,  '1, '1, 1'b1, '1));
    offer(mk_req(FUNC_READ,   '0, '0, 1'b0, '0));
    offer(mk_req(FUNC_INSERT, '0, 32'd7, 1'b1, '0));
    offer(mk_req(FUNC_INSERT, 24'h80_0000, 32'h8000_0000, 1'b1, '0));
    offer(mk_req(FUNC_INSERT, 24'h7F_FFFF, 32'h7FFF_FFFF, 1'b0, '0));
    offer(mk_req(FUNC_READ,   '0, '0, 1'b0, 6'd1));

    // Random phase with a stretch free of idle cycles, one long response stall and one drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) no_idle = 1'b1;
      if (n == 700) no_idle = 1'b0;
      if (n == 900) hold_rsp = 1'b1;
      if (n == 1300) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0) @(posedge clk);
      end
      offer(random_req());
    end
    req_ch.valid <= 1'b0;

    // Wait out the tail
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0)
      $display("[sorted_candidate_pool_insert_top] OK");
    else
      $display("[sorted_candidate_pool_insert_top] ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/scpi_pkg.sv
hdl/scpi_req_if.sv
hdl/scpi_rsp_if.sv
hdl/scpi_ram.sv
hdl/scpi_scan.sv
hdl/sorted_candidate_pool_insert_top.sv
tb/scpi_pool_checker.sv
tb/tb_top.sv
